@@ hw/rtl/ctf_pkg.sv @@
`default_nettype none

package ctf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 6;

  localparam int DATA_W     = 16;
  localparam int CORDIC_XW  = 27;
  localparam int CORDIC_ZW  = 27;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
  localparam int MUL_BW     = 17;
  localparam int SQRT_RW    = 24;
  localparam int SD_W       = 20;
  localparam int PROD_W     = 35;
  localparam int DIV_RW     = 20;
  localparam int SAT_W      = 32;

  localparam logic [DIV_RW:0]   GYRO_DIV   = 21'd1000000;
  localparam logic [DIV_RW-1:0] GYRO_BIAS  = 20'd500000;
  localparam logic [MUL_BW-1:0] WEIGHT_ONE = 17'h10000;

  localparam logic signed [CORDIC_ZW-1:0] DEG180_Q16 = 27'sd11796480;

  // configuration register indexes, byte address is 4 * index
  typedef enum logic [1:0] {
    REG_BLEND  = 2'd0,
    REG_PERIOD = 2'd1,
    REG_SENS   = 2'd2
  } reg_idx_t;

  localparam int REG_COUNT = 3;

  typedef struct packed {
    logic start;
    logic accum;
  } mul_ctl_t;

  // arctan(2^-i) in degrees * 2^16
  function automatic logic signed [CORDIC_ZW-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CORDIC_ZW-1:0] r;
    case (idx)
      0:  r = 27'sd2949120;
      1:  r = 27'sd1740967;
      2:  r = 27'sd919879;
      3:  r = 27'sd466945;
      4:  r = 27'sd234379;
      5:  r = 27'sd117304;
      6:  r = 27'sd58666;
      7:  r = 27'sd29335;
      8:  r = 27'sd14668;
      9:  r = 27'sd7334;
      10: r = 27'sd3667;
      11: r = 27'sd1833;
      12: r = 27'sd917;
      13: r = 27'sd458;
      14: r = 27'sd229;
      15: r = 27'sd115;
      16: r = 27'sd57;
      17: r = 27'sd29;
      18: r = 27'sd14;
      19: r = 27'sd7;
      20: r = 27'sd4;
      21: r = 27'sd2;
      22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/imu_complementary_tilt_filter.sv @@
`default_nettype none

// channel  | direction | handshake               | payload
// s_*      | in        | s_tvalid / s_tready     | accel_x, accel_y, accel_z, rate_x, rate_y
// m_*      | out       | m_tvalid / m_tready     | roll_angle, pitch_angle
// apb      | in        | psel & penable & pwrite | blend_weight, sample_period_ms,
//          |           |                         | gyro_mdps_per_lsb
//
// one item at a time: the first item after reset only seeds the stored angles (two
// squares, the 24-step root and two cordic runs); each later item runs nine passes of
// the 17-bit serial multiplier, the 24-step root, two cordic runs and two bit-serial
// divisions of the gyro term.
// s_tready is high only while idle; a result waiting on m_tready holds the block
// in its output state. rst clears stored angles and seed flag and resets registers to defaults.
module imu_complementary_tilt_filter import ctf_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // roll_angle, pitch_angle
  output logic [31:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = CORDIC_ZW + F;
  localparam int QW = F + 32;
  localparam int NW = PROD_W + F + 16;
  localparam int GW = QW + 2;
  localparam int VW = GW + MUL_BW;
  localparam logic signed [VW-1:0] RND32 = VW'(64'd1 << 31);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_Y,
    S_SQ_Z,
    S_SQRT,
    S_CORD_R,
    S_CORD_P,
    S_SEED,
    S_SD,
    S_PROD,
    S_DIV,
    S_BL_G,
    S_BL_A,
    S_OUT
  } state_t;

  state_t state;
  logic   busy;
  logic   seeded;
  logic   axis;

  logic [15:0] blend_w;
  logic [9:0]  period;
  logic [9:0]  sens;

  logic signed [DATA_W-1:0] ax;
  logic signed [DATA_W-1:0] ay;
  logic signed [DATA_W-1:0] az;
  logic signed [DATA_W-1:0] gx;
  logic signed [DATA_W-1:0] gy;
  logic signed [DATA_W-1:0] roll_store;
  logic signed [DATA_W-1:0] pitch_store;
  logic signed [AW-1:0]     a_roll;
  logic signed [AW-1:0]     a_pitch;
  logic [SD_W-1:0]          sd;

  // unit hookup
  mul_ctl_t                    mul_ctl;
  logic signed [VW-1:0]        mul_a;
  logic [MUL_BW-1:0]           mul_b;
  logic signed [VW-1:0]        mul_prod;
  logic                        mul_done;
  logic                        sqrt_start;
  logic [SQRT_RW-1:0]          sqrt_root;
  logic                        sqrt_done;
  logic                        cord_start;
  logic signed [CORDIC_XW-1:0] cord_x;
  logic signed [CORDIC_XW-1:0] cord_y;
  logic signed [CORDIC_ZW-1:0] cord_z;
  logic                        cord_done;
  logic                        div_start;
  logic [NW-1:0]               div_n;
  logic [QW-1:0]               div_q;
  logic                        div_done;
  logic                        unit_start;

  logic [DATA_W-1:0]        ay_mag;
  logic [DATA_W-1:0]        az_mag;
  logic signed [DATA_W-1:0] g_sel;
  logic [DATA_W-1:0]        g_mag;
  logic signed [DATA_W-1:0] st_sel;
  logic signed [AW-1:0]     a_sel;
  logic signed [QW:0]       gterm;
  logic signed [GW-1:0]     gsum;
  logic signed [VW-1:0]     v_rnd;
  logic signed [VW-33:0]    v_top;
  logic signed [DATA_W-1:0] blend_val;
  logic signed [AW-1:0]     seed_r_sum;
  logic signed [AW-1:0]     seed_p_sum;
  logic signed [AW-17:0]    seed_r_top;
  logic signed [AW-17:0]    seed_p_top;
  logic signed [DATA_W-1:0] seed_roll;
  logic signed [DATA_W-1:0] seed_pitch;

  always_comb begin
    ay_mag = ay[DATA_W-1] ? DATA_W'(-ay) : DATA_W'(ay);
    az_mag = az[DATA_W-1] ? DATA_W'(-az) : DATA_W'(az);
    g_sel  = axis ? gy : gx;
    g_mag  = g_sel[DATA_W-1] ? DATA_W'(-g_sel) : DATA_W'(g_sel);
    st_sel = axis ? pitch_store : roll_store;
    a_sel  = axis ? a_pitch : a_roll;

    gterm = g_sel[DATA_W-1] ? -signed'({1'b0, div_q}) : signed'({1'b0, div_q});
    gsum  = (GW'(st_sel) <<< 16) + GW'(gterm);

    // blend result: round half up at bit 32, then clamp
    v_rnd     = mul_prod + RND32;
    v_top     = signed'(v_rnd[VW-1:32]);
    blend_val = sat16(SAT_W'(v_top));

    seed_r_sum = a_roll + AW'(32768);
    seed_p_sum = a_pitch + AW'(32768);
    seed_r_top = signed'(seed_r_sum[AW-1:16]);
    seed_p_top = signed'(seed_p_sum[AW-1:16]);
    seed_roll  = sat16(SAT_W'(seed_r_top));
    seed_pitch = sat16(SAT_W'(seed_p_top));
  end

  always_comb begin
    mul_ctl    = '0;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    cord_start = 1'b0;
    cord_x     = '0;
    cord_y     = '0;
    div_start  = 1'b0;
    case (state)
      S_SQ_Y: begin
        mul_ctl.start = !busy;
        mul_a         = VW'(ay_mag);
        mul_b         = MUL_BW'(ay_mag);
      end
      S_SQ_Z: begin
        mul_ctl.start = !busy;
        mul_ctl.accum = 1'b1;
        mul_a         = VW'(az_mag);
        mul_b         = MUL_BW'(az_mag);
      end
      S_SQRT: begin
        sqrt_start = !busy;
      end
      S_CORD_R: begin
        cord_start = !busy;
        cord_x     = CORDIC_XW'(signed'({az, 8'h00}));
        cord_y     = CORDIC_XW'(signed'({ay, 8'h00}));
      end
      S_CORD_P: begin
        cord_start = !busy;
        cord_x     = CORDIC_XW'(signed'({1'b0, sqrt_root}));
        cord_y     = -CORDIC_XW'(signed'({ax, 8'h00}));
      end
      S_SD: begin
        mul_ctl.start = !busy;
        mul_a         = VW'(sens);
        mul_b         = MUL_BW'(period);
      end
      S_PROD: begin
        mul_ctl.start = !busy;
        mul_a         = VW'(sd);
        mul_b         = MUL_BW'(g_mag);
      end
      S_DIV: begin
        div_start = !busy;
      end
      S_BL_G: begin
        mul_ctl.start = !busy;
        mul_a         = VW'(gsum);
        mul_b         = MUL_BW'(blend_w);
      end
      S_BL_A: begin
        mul_ctl.start = !busy;
        mul_ctl.accum = 1'b1;
        mul_a         = VW'(a_sel);
        mul_b         = WEIGHT_ONE - MUL_BW'(blend_w);
      end
      default: begin
      end
    endcase
  end

  // radicand is (ay^2 + az^2) * 2^16; dividend is p * 2^(F+16) + 5e5
  assign div_n      = {mul_prod[PROD_W-1:0], (F + 16)'(GYRO_BIAS)};
  assign unit_start = mul_ctl.start | sqrt_start | cord_start | div_start;

  ctf_serial_mul #(.VW(VW)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mul_ctl),
    .mcand  (mul_a),
    .mplier (mul_b),
    .prod   (mul_prod),
    .done   (mul_done)
  );

  ctf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({mul_prod[31:0], 16'h0000}),
    .root     (sqrt_root),
    .done     (sqrt_done)
  );

  ctf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .x_in  (cord_x),
    .y_in  (cord_y),
    .z_out (cord_z),
    .done  (cord_done)
  );

  ctf_divider #(.NW(NW), .QW(QW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .quotient (div_q),
    .done     (div_done)
  );

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_BLEND:  prdata = {16'h0000, blend_w};
      REG_PERIOD: prdata = {22'h0, period};
      REG_SENS:   prdata = {22'h0, sens};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      busy        <= 1'b0;
      seeded      <= 1'b0;
      axis        <= 1'b0;
      roll_store  <= '0;
      pitch_store <= '0;
      m_tvalid    <= 1'b0;
      blend_w     <= 16'd64225;
      period      <= 10'd20;
      sens        <= 10'd70;
    end else begin
      if (psel && penable && pwrite) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_BLEND:  blend_w <= pwdata[15:0];
          REG_PERIOD: period  <= pwdata[9:0];
          REG_SENS:   sens    <= pwdata[9:0];
          default: begin
          end
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (unit_start) begin
        busy <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ax    <= signed'(s_tdata[15:0]);
            ay    <= signed'(s_tdata[31:16]);
            az    <= signed'(s_tdata[47:32]);
            gx    <= signed'(s_tdata[63:48]);
            gy    <= signed'(s_tdata[79:64]);
            axis  <= 1'b0;
            state <= S_SQ_Y;
          end
        end
        S_SQ_Y: begin
          if (mul_done) begin
            busy  <= 1'b0;
            state <= S_SQ_Z;
          end
        end
        S_SQ_Z: begin
          if (mul_done) begin
            busy  <= 1'b0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            busy  <= 1'b0;
            state <= S_CORD_R;
          end
        end
        S_CORD_R: begin
          if (cord_done) begin
            busy   <= 1'b0;
            a_roll <= signed'({cord_z, {F{1'b0}}});
            state  <= S_CORD_P;
          end
        end
        S_CORD_P: begin
          if (cord_done) begin
            busy    <= 1'b0;
            a_pitch <= signed'({cord_z, {F{1'b0}}});
            state   <= seeded ? S_SD : S_SEED;
          end
        end
        S_SEED: begin
          roll_store  <= seed_roll;
          pitch_store <= seed_pitch;
          seeded      <= 1'b1;
          state       <= S_OUT;
        end
        S_SD: begin
          if (mul_done) begin
            busy  <= 1'b0;
            sd    <= mul_prod[SD_W-1:0];
            state <= S_PROD;
          end
        end
        S_PROD: begin
          if (mul_done) begin
            busy  <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            busy  <= 1'b0;
            state <= S_BL_G;
          end
        end
        S_BL_G: begin
          if (mul_done) begin
            busy  <= 1'b0;
            state <= S_BL_A;
          end
        end
        S_BL_A: begin
          if (mul_done) begin
            busy <= 1'b0;
            if (!axis) begin
              roll_store <= blend_val;
              axis       <= 1'b1;
              state      <= S_PROD;
            end else begin
              pitch_store <= blend_val;
              state       <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {pitch_store, roll_store};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ctf_serial_mul.sv @@
`default_nettype none

// shift-and-add multiplier, one multiplier bit per cycle, optional accumulate
module ctf_serial_mul import ctf_pkg::*; #(
  parameter int VW = ANGLE_FRAC_DEF + 51
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mul_ctl_t             ctl,
  input  wire logic signed [VW-1:0] mcand,
  input  wire logic [MUL_BW-1:0]    mplier,
  output logic signed [VW-1:0]      prod,
  output logic                      done
);

  localparam int MCW = $clog2(MUL_BW);

  logic signed [VW-1:0] m;
  logic [MUL_BW-1:0]    b;
  logic [MCW-1:0]       cnt;
  logic                 busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        prod <= ctl.accum ? prod : '0;
        m    <= mcand;
        b    <= mplier;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (b[0]) begin
          prod <= prod + m;
        end
        m   <= m <<< 1;
        b   <= b >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == MCW'(MUL_BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ctf_sqrt.sv @@
`default_nettype none

// digit-by-digit integer square root, two radicand bits per cycle
module ctf_sqrt import ctf_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [2*SQRT_RW-1:0]   radicand,
  output logic [SQRT_RW-1:0]          root,
  output logic                        done
);

  localparam int SCW = $clog2(SQRT_RW);

  logic [2*SQRT_RW-1:0] rad;
  logic [SQRT_RW+1:0]   rem;
  logic [SCW-1:0]       cnt;
  logic                 busy;

  logic [SQRT_RW+3:0]   t;
  logic [SQRT_RW+3:0]   trial;
  logic [SQRT_RW+3:0]   diff;
  logic                 fits;

  always_comb begin
    t     = {rem, rad[2*SQRT_RW-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    diff  = t - trial;
    fits  = (t >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem  <= diff[SQRT_RW+1:0];
          root <= {root[SQRT_RW-2:0], 1'b1};
        end else begin
          rem  <= t[SQRT_RW+1:0];
          root <= {root[SQRT_RW-2:0], 1'b0};
        end
        rad <= rad << 2;
        cnt <= cnt + 1'b1;
        if (cnt == SCW'(SQRT_RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ctf_cordic.sv @@
`default_nettype none

// vectoring cordic, one micro-rotation per cycle, angle in degrees * 2^16
module ctf_cordic import ctf_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [CORDIC_XW-1:0] x_in,
  input  wire logic signed [CORDIC_XW-1:0] y_in,
  output logic signed [CORDIC_ZW-1:0]      z_out,
  output logic                             done
);

  logic signed [CORDIC_XW-1:0] x;
  logic signed [CORDIC_XW-1:0] y;
  logic [ATAN_IDX_W-1:0]       i;
  logic                        busy;

  logic signed [CORDIC_XW-1:0] dx;
  logic signed [CORDIC_XW-1:0] dy;
  logic signed [CORDIC_ZW-1:0] step_angle;

  always_comb begin
    dx         = x >>> i;
    dy         = y >>> i;
    step_angle = atan_q16(i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        i <= '0;
        if (x_in == '0 && y_in == '0) begin
          z_out <= '0;
          done  <= 1'b1;
        end else begin
          busy <= 1'b1;
          // left half-plane: turn the vector by 180 degrees first
          if (x_in < 0) begin
            x     <= -x_in;
            y     <= -y_in;
            z_out <= (y_in >= 0) ? DEG180_Q16 : -DEG180_Q16;
          end else begin
            x     <= x_in;
            y     <= y_in;
            z_out <= '0;
          end
        end
      end else if (busy) begin
        if (y >= 0) begin
          x     <= x + dy;
          y     <= y - dx;
          z_out <= z_out + step_angle;
        end else begin
          x     <= x - dy;
          y     <= y + dx;
          z_out <= z_out - step_angle;
        end
        i <= i + 1'b1;
        if (i == ATAN_IDX_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ctf_divider.sv @@
`default_nettype none

// restoring division by the fixed 1e6 scale, one quotient bit per cycle
module ctf_divider import ctf_pkg::*; #(
  parameter int NW = PROD_W + ANGLE_FRAC_DEF + 16,
  parameter int QW = ANGLE_FRAC_DEF + 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  output logic [QW-1:0]      quotient,
  output logic               done
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0]     n;
  logic [DIV_RW-1:0] rem;
  logic [CW-1:0]     cnt;
  logic              busy;

  logic [DIV_RW:0]   t;
  logic [DIV_RW:0]   diff;
  logic              fits;

  always_comb begin
    t    = {rem, n[NW-1]};
    diff = t - GYRO_DIV;
    fits = (t >= GYRO_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n        <= dividend;
        rem      <= '0;
        quotient <= '0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= fits ? diff[DIV_RW-1:0] : t[DIV_RW-1:0];
        quotient <= {quotient[QW-2:0], fits};
        n        <= n << 1;
        cnt      <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
module tb;
  import ctf_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 98;
  localparam int PRESSURE_AT  = 250;
  localparam int PRESSURE_LEN = 1500;

  // accel_x sits in the low bits
  typedef struct packed {
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_x;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
  } imu_sample_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } tilt_t;

  class tilt_tracker;
    tilt_t  pending_tilts[$];
    int     errors;
    longint roll_q;
    longint pitch_q;
    bit     seeded;
    longint weight;
    longint period_ms;
    longint mdps;
    longint atan_deg[24];

    function new();
      atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115,
                   57, 29, 14, 7, 4, 2, 1, 0};
      errors    = 0;
      roll_q    = 0;
      pitch_q   = 0;
      seeded    = 0;
      weight    = 64225;
      period_ms = 20;
      mdps      = 70;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] d);
      case (idx)
        REG_BLEND:  weight = d[15:0];
        REG_PERIOD: period_ms = d[9:0];
        REG_SENS:   mdps = d[9:0];
        default: ;
      endcase
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint root_floor(longint n);
      longint res, b;
      res = 0;
      b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - res - b;
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // vectoring cordic, degrees * 2^16
    function longint cordic_deg(longint x, longint y);
      longint z, base, dx, dy;
      z = 0;
      base = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        base = (y >= 0) ? 180 * 65536 : -180 * 65536;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (y >= 0) begin
          x = x + dy;
          y = y - dx;
          z = z + atan_deg[i];
        end else begin
          x = x - dy;
          y = y + dx;
          z = z - atan_deg[i];
        end
      end
      return base + z;
    endfunction

    function longint gyro_step(longint rate);
      longint mag, q;
      mag = (rate < 0) ? -rate : rate;
      q = (mag * mdps * period_ms * (longint'(1) << (ANGLE_FRAC_DEF + 16)) + 500000)
          / 1000000;
      return (rate < 0) ? -q : q;
    endfunction

    function longint mix(longint stored, longint rate, longint acc);
      longint g, v;
      g = stored * 65536 + gyro_step(rate);
      v = weight * g + (65536 - weight) * acc;
      return clamp16((v + (longint'(1) << 31)) >>> 32);
    endfunction

    function void take_sample(imu_sample_t s);
      longint ax, ay, az, m, acc_r, acc_p;
      tilt_t t;
      ax = s.accel_x;
      ay = s.accel_y;
      az = s.accel_z;
      m = root_floor((ay * ay + az * az) << 16);
      acc_r = cordic_deg(az * 256, ay * 256) * (longint'(1) << ANGLE_FRAC_DEF);
      acc_p = cordic_deg(m, -ax * 256) * (longint'(1) << ANGLE_FRAC_DEF);
      if (!seeded) begin
        roll_q  = clamp16((acc_r + 32768) >>> 16);
        pitch_q = clamp16((acc_p + 32768) >>> 16);
        seeded  = 1;
      end else begin
        roll_q  = mix(roll_q, s.rate_x, acc_r);
        pitch_q = mix(pitch_q, s.rate_y, acc_p);
      end
      t.roll_angle  = roll_q[15:0];
      t.pitch_angle = pitch_q[15:0];
      pending_tilts.push_back(t);
    endfunction

    function void check_angles(logic [31:0] d);
      tilt_t got, want;
      got = d;
      if (pending_tilts.size() == 0) begin
        $error("angles %h arrived with no sample pending", d);
        errors++;
        return;
      end
      want = pending_tilts.pop_front();
      if (got.roll_angle !== want.roll_angle) begin
        $error("roll_angle expected %0d got %0d", want.roll_angle, got.roll_angle);
        errors++;
      end
      if (got.pitch_angle !== want.pitch_angle) begin
        $error("pitch_angle expected %0d got %0d", want.pitch_angle, got.pitch_angle);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tilt_tracker tracker = new();
  bit calm;

  imu_complementary_tilt_filter #(
    .CORDIC_STEPS    (CORDIC_STEPS_DEF),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_DEF)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // mostly short idles, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 4);
    if (r < 19) return $urandom_range(5, 40);
    return $urandom_range(80, 500);
  endfunction

  function automatic logic [15:0] small_s16(int r);
    int t;
    t = $urandom_range(0, 2 * r);
    t = t - r;
    return 16'(t);
  endfunction

  function automatic logic [15:0] edge_s16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'hffff;
      2: return 16'h0000;
      3: return 16'h0001;
      4: return 16'h7fff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    case ($urandom_range(0, 9))
      0, 1, 2: s = imu_sample_t'({$urandom(), $urandom(), 16'($urandom())});
      3, 4: begin
        s.accel_x = edge_s16();
        s.accel_y = edge_s16();
        s.accel_z = edge_s16();
        s.rate_x  = edge_s16();
        s.rate_y  = edge_s16();
      end
      default: begin
        s.accel_x = small_s16(18000);
        s.accel_y = small_s16(18000);
        s.accel_z = small_s16(18000);
        s.rate_x  = small_s16(1500);
        s.rate_y  = small_s16(1500);
      end
    endcase
    return s;
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return 64225;
      3: return 32768;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 1000;
      3: return 1023;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  // optional garbage above the register width
  function automatic logic [31:0] pad(int v, int width, bit junk);
    logic [31:0] hi;
    hi = junk ? ($urandom() << width) : 32'd0;
    return hi | 32'(v);
  endfunction

  // psel stays up between back-to-back writes; bus_release drops it
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= 4'(int'(idx) * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, data);
  endtask

  task automatic bus_release();
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  task automatic load_settings(input int w, input int dt, input int sens, input bit junk,
                               input bit spare);
    reg_write(REG_BLEND, pad(w, 16, junk));
    reg_write(REG_PERIOD, pad(dt, 10, junk));
    reg_write(REG_SENS, pad(sens, 10, junk));
    // index one past the last register
    if (spare) reg_write(reg_idx_t'(REG_COUNT), $urandom());
    bus_release();
  endtask

  task automatic offer_sample(input imu_sample_t s);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= s;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    tracker.take_sample(s);
  endtask

  task automatic offer_fields(input int ax, input int ay, input int az, input int rx,
                              input int ry);
    imu_sample_t s;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.rate_x  = 16'(rx);
    s.rate_y  = 16'(ry);
    offer_sample(s);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (tracker.pending_tilts.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin : stimulus
    rst      <= 1;
    s_tvalid <= 0;
    s_tdata  <= '0;
    psel     <= 0;
    penable  <= 0;
    pwrite   <= 0;
    paddr    <= '0;
    pwdata   <= '0;
    calm = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings; first sample seeds, roll lands near -180
    offer_fields(1000, -5, -16000, 0, 0);
    offer_fields(0, 0, 0, 0, 0);
    offer_fields(0, 0, 16384, 32767, -32768);
    offer_fields(-32768, 32767, -32768, -32768, 32767);
    offer_fields(32767, -32768, 0, 1, -1);
    offer_fields(0, 0, -5, 100, -100);
    offer_fields(0, -1, -1, 0, 0);
    offer_fields(-32768, 0, 0, 0, 0);
    offer_fields(32767, 32767, 32767, 32767, 32767);
    drain();

    // accel only, widest gyro scale
    load_settings(0, 1023, 1023, 1, 1);
    offer_fields(-32768, -32768, -32768, -32768, -32768);
    offer_fields(100, 200, 16000, 32767, -32768);
    offer_fields(0, 0, 0, -1, 1);
    drain();

    // near-full gyro weight at full scale drives both angles into saturation
    load_settings(65535, 1023, 1023, 0, 0);
    repeat (4) offer_fields(0, 0, 16384, 32767, -32768);
    repeat (2) offer_fields(0, 0, 16384, -32768, 32767);
    drain();

    // zero dt: no gyro contribution
    load_settings(65535, 0, 1000, 0, 0);
    offer_fields(5000, -3000, 12000, 32767, 32767);
    offer_fields(0, 0, 0, 0, 0);
    drain();

    // zero sensitivity
    load_settings(32768, 1, 0, 1, 0);
    offer_fields(-20000, 8000, -9000, -32768, 32767);
    offer_fields(1, 1, 1, 1, 1);
    drain();

    load_settings(1, 1000, 1, 0, 0);
    offer_fields(12000, -16000, 100, 1234, -4321);
    offer_fields(-1, -1, -1, -1, -1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      calm = ($urandom_range(0, 4) == 0);
      load_settings(pick_weight(), pick_step(), pick_step(), $urandom_range(0, 1),
                    $urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) offer_sample(random_sample());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    int results_seen;
    stall = 0;
    results_seen = 0;
    m_tready <= 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (m_tvalid && m_tready) begin
        tracker.check_angles(m_tdata);
        results_seen++;
        // long hold-off so the block backs up and blocks its input
        if (results_seen == PRESSURE_AT) stall = PRESSURE_LEN;
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else begin
        if (!calm && $urandom_range(0, 11) == 0) stall = idle_length();
        m_tready <= (stall == 0);
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
